### rtl/ckpm_pkg.sv
// Package: shared types, register indexes and constants for the color key mask core.
`timescale 1ns / 1ps
package ckpm_pkg;
    localparam int unsigned CfgIdxBits = 3;
    localparam int unsigned CfgDataBits = 24;
    localparam logic [CfgIdxBits-1:0] REG_CONTROL_FLAGS  = 3'd0;
    localparam logic [CfgIdxBits-1:0] REG_DISTANCE_LIMIT = 3'd1;
    localparam logic [CfgIdxBits-1:0] REG_TARGET_RGB     = 3'd2;
    localparam logic [CfgIdxBits-1:0] REG_TARGET_HSV     = 3'd3;
    localparam logic [CfgIdxBits-1:0] REG_HSV_SPREADS    = 3'd4;
    localparam logic [CfgIdxBits-1:0] REG_FRAME_PIXELS   = 3'd5;

    localparam logic [7:0] MaskOn  = 8'd255;
    localparam logic [7:0] MaskOff = 8'd0;
    localparam logic [9:0] RedBase  = 10'd512;
    localparam logic [9:0] BlueBase = 10'd767;
    localparam logic [7:0] HueSector = 8'd43;
    localparam logic [7:0] HueBaseG  = 8'd85;
    localparam logic [7:0] HueBaseB  = 8'd171;
    localparam logic [7:0] HueHalf   = 8'd128;

    // reciprocal table: ceil(2^24 / d) for d in 1..255, entry 0 unused;
    // (n * entry) >> 24 gives floor(n / d) exactly for n < 2^16
    typedef logic [255:0][24:0] t_recip_tab;

    function automatic t_recip_tab build_recip();
        t_recip_tab tab;
        tab[0] = '0;
        for (int d = 1; d < 256; d++) begin
            tab[d] = 25'((32'd16777216 + 32'(d) - 32'd1) / 32'(d));
        end
        return tab;
    endfunction

    localparam t_recip_tab RecipTab = build_recip();

    typedef struct packed {
        logic       hsv_mode;
        logic       use_alpha;
        logic       bottom_only;
        logic       hue_chk;
        logic       sat_chk;
        logic       val_chk;
    } t_flags;
endpackage

### rtl/ckpm_hsv_pipe.sv
// Three-stage HSV conversion and check path with stall-controlled advance.
`timescale 1ns / 1ps
module ckpm_hsv_pipe (
    input  logic                  i_clk,
    input  logic [2:0]            i_adv,
    input  logic [7:0]            i_red,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_blue,
    input  ckpm_pkg::t_flags      i_flags,
    input  logic [23:0]           i_target_hsv,
    input  logic [23:0]           i_hsv_spreads,
    output logic                  o_hsv_ok
);
    // stage 1: max, min, numerators, divisors
    logic [7:0]  n_mx, n_mn, n_dlt, n_hdiff;
    logic        n_hneg;
    logic [7:0]  n_hbase;
    logic [7:0]  r_mx, r_dlt, r_hbase;
    logic [15:0] r_snum;
    logic [14:0] r_hnum;
    logic        r_hneg;
    logic [24:0] r_srec, r_hrec;

    always_comb begin
        n_mx = i_red;
        if (i_green > n_mx) n_mx = i_green;
        if (i_blue > n_mx) n_mx = i_blue;
        n_mn = i_red;
        if (i_green < n_mn) n_mn = i_green;
        if (i_blue < n_mn) n_mn = i_blue;
        n_dlt = n_mx - n_mn;
        if (n_mx == i_red) begin
            n_hbase = 8'd0;
            n_hneg = i_green < i_blue;
            n_hdiff = n_hneg ? i_blue - i_green : i_green - i_blue;
        end else if (n_mx == i_green) begin
            n_hbase = ckpm_pkg::HueBaseG;
            n_hneg = i_blue < i_red;
            n_hdiff = n_hneg ? i_red - i_blue : i_blue - i_red;
        end else begin
            n_hbase = ckpm_pkg::HueBaseB;
            n_hneg = i_red < i_green;
            n_hdiff = n_hneg ? i_green - i_red : i_red - i_green;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_mx <= n_mx;
            r_dlt <= n_dlt;
            r_hbase <= n_hbase;
            r_hneg <= n_hneg;
            r_snum <= 16'(n_dlt) * 16'd255;
            r_hnum <= 15'(n_hdiff) * 15'(ckpm_pkg::HueSector);
            r_srec <= ckpm_pkg::RecipTab[n_mx];
            r_hrec <= ckpm_pkg::RecipTab[n_dlt];
        end
    end

    // stage 2: reciprocal multiplies (16 x 25), floor via >> 24
    logic [39:0] n_sprod, n_hprod;
    logic [7:0]  r_s, r_hmag, r_v, r_hbase2;
    logic        r_hneg2, r_szero;
    assign n_sprod = 40'(r_snum) * 40'(r_srec);
    assign n_hprod = 40'(r_hnum) * 40'(r_hrec);
    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            r_v <= r_mx;
            r_s <= (r_mx == 8'd0) ? 8'd0 : n_sprod[31:24];
            r_hmag <= (r_dlt == 8'd0) ? 8'd0 : n_hprod[31:24];
            r_hneg2 <= r_hneg;
            r_hbase2 <= r_hbase;
            r_szero <= (r_mx == 8'd0) || (r_dlt == 8'd0);
        end
    end

    // stage 3: hue, distances and compares
    logic [7:0] w_h, w_s, w_dh, w_ds, w_dv, w_th, w_ts, w_tv;
    logic       n_ok;
    always_comb begin
        w_th = i_target_hsv[23:16];
        w_ts = i_target_hsv[15:8];
        w_tv = i_target_hsv[7:0];
        w_s = r_szero ? 8'd0 : r_s;
        w_h = r_szero ? 8'd0 : (r_hneg2 ? r_hbase2 - r_hmag : r_hbase2 + r_hmag);
        w_dh = (w_h > w_th) ? w_h - w_th : w_th - w_h;
        if (w_dh > ckpm_pkg::HueHalf) w_dh = 8'd255 - w_dh;
        w_ds = (w_s > w_ts) ? w_s - w_ts : w_ts - w_s;
        w_dv = (r_v > w_tv) ? r_v - w_tv : w_tv - r_v;
        n_ok = 1'b1;
        if (i_flags.hue_chk && w_dh > i_hsv_spreads[23:16]) n_ok = 1'b0;
        if (i_flags.sat_chk && w_ds > i_hsv_spreads[15:8]) n_ok = 1'b0;
        if (i_flags.val_chk && w_dv > i_hsv_spreads[7:0]) n_ok = 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (i_adv[2]) o_hsv_ok <= n_ok;
    end
endmodule

### rtl/color_key_pixel_mask_core.sv
// Top level: color key pixel mask core with a four-stage pipeline.
// Channel  | Dir | Payload
// s_axis   | in  | tdata: pixel_index, red, green, blue, alpha_value
// m_axis   | out | tdata: mask_value
// cfg      | in  | i_cfg_we, i_cfg_idx, i_cfg_data
// One pixel per clock sustained while m_axis_tready is high; the depth is set by the HSV
// divide-by-reciprocal path (operand stage, multiply stage, compare stage,
// output register). The RGB path runs in parallel through the same stages.
// Reset clears the valid bits and the configuration registers. A stall on
// m_axis holds each valid stage only while all later stages are full; bubbles are squeezed out.
`timescale 1ns / 1ps
module color_key_pixel_mask_core #(
    parameter int unsigned PIXEL_INDEX_BITS = 22,
    localparam int unsigned InBits = PIXEL_INDEX_BITS + 32,
    localparam int unsigned InBytes = (InBits + 7) / 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pixel_index, red, green, blue, alpha_value (low to high), zero padded
    input  logic [InBytes*8-1:0]              s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // mask_value
    output logic [7:0]                        m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [ckpm_pkg::CfgIdxBits-1:0]   i_cfg_idx,
    input  logic [ckpm_pkg::CfgDataBits-1:0]  i_cfg_data
);
    localparam int unsigned P = PIXEL_INDEX_BITS;

    ckpm_pkg::t_flags r_flags;
    logic [9:0]  r_limit;
    logic [23:0] r_trgb, r_thsv, r_spread;
    logic [22:0] r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_limit <= '0;
            r_trgb <= '0;
            r_thsv <= '0;
            r_spread <= '0;
            r_frame <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ckpm_pkg::REG_CONTROL_FLAGS:  r_flags <= ckpm_pkg::t_flags'({i_cfg_data[0],
                    i_cfg_data[1], i_cfg_data[2], i_cfg_data[3], i_cfg_data[4],
                    i_cfg_data[5]});
                ckpm_pkg::REG_DISTANCE_LIMIT: r_limit <= i_cfg_data[9:0];
                ckpm_pkg::REG_TARGET_RGB:     r_trgb <= i_cfg_data;
                ckpm_pkg::REG_TARGET_HSV:     r_thsv <= i_cfg_data;
                ckpm_pkg::REG_HSV_SPREADS:    r_spread <= i_cfg_data;
                ckpm_pkg::REG_FRAME_PIXELS:   r_frame <= i_cfg_data[22:0];
                default: ;
            endcase
        end
    end

    // valid chain and advance
    logic [3:0] r_vld;
    logic [3:0] w_adv;
    assign w_adv[3] = !r_vld[3] || m_axis_tready;
    assign w_adv[2] = !r_vld[2] || w_adv[3];
    assign w_adv[1] = !r_vld[1] || w_adv[2];
    assign w_adv[0] = !r_vld[0] || w_adv[1];
    assign s_axis_tready = w_adv[0];
    assign m_axis_tvalid = r_vld[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= s_axis_tvalid;
            if (w_adv[1]) r_vld[1] <= r_vld[0];
            if (w_adv[2]) r_vld[2] <= r_vld[1];
            if (w_adv[3]) r_vld[3] <= r_vld[2];
        end
    end

    logic [P-1:0] w_idx;
    logic [7:0]   w_r, w_g, w_b, w_a;
    assign w_idx = s_axis_tdata[P-1:0];
    assign w_r = s_axis_tdata[P+7:P];
    assign w_g = s_axis_tdata[P+15:P+8];
    assign w_b = s_axis_tdata[P+23:P+16];
    assign w_a = s_axis_tdata[P+31:P+24];

    // stage 1: exclusion and RGB differences
    logic       n_excl;
    logic [22:0] w_half;
    logic [7:0] w_dr, w_dg, w_db, w_tr, w_tg, w_tb;
    logic [8:0] w_rsum;
    assign w_half = {1'b0, r_frame[22:1]};
    assign w_tr = r_trgb[23:16];
    assign w_tg = r_trgb[15:8];
    assign w_tb = r_trgb[7:0];
    assign w_dr = (w_tr > w_r) ? w_tr - w_r : w_r - w_tr;
    assign w_dg = (w_tg > w_g) ? w_tg - w_g : w_g - w_tg;
    assign w_db = (w_tb > w_b) ? w_tb - w_b : w_b - w_tb;
    assign w_rsum = 9'(w_tr) + 9'(w_r);
    assign n_excl = (r_flags.bottom_only && (33'(w_idx) < 33'(w_half)))
                 || (r_flags.use_alpha && w_a == 8'd0);

    logic [3:1] r_excl;
    logic [15:0] r_dr2, r_dg2, r_db2;
    logic [7:0]  r_rmean;
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_excl[1] <= n_excl;
            r_dr2 <= 16'(w_dr) * 16'(w_dr);
            r_dg2 <= 16'(w_dg) * 16'(w_dg);
            r_db2 <= 16'(w_db) * 16'(w_db);
            r_rmean <= w_rsum[8:1];
        end
    end

    // stage 2: weighted products
    logic [25:0] r_wr, r_wb;
    logic [17:0] r_g4;
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_excl[2] <= r_excl[1];
            r_wr <= 26'(ckpm_pkg::RedBase + 10'(r_rmean)) * 26'(r_dr2);
            r_wb <= 26'(ckpm_pkg::BlueBase - 10'(r_rmean)) * 26'(r_db2);
            r_g4 <= {r_dg2, 2'b00};
        end
    end

    // stage 3: sum and compare against limit squared
    logic [19:0] w_sum, w_lim2;
    logic        r_rgb_ok;
    assign w_sum = 20'(r_wr[25:8]) + 20'(r_g4) + 20'(r_wb[25:8]);
    assign w_lim2 = 20'(r_limit) * 20'(r_limit);
    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_excl[3] <= r_excl[2];
            r_rgb_ok <= w_sum <= w_lim2;
        end
    end

    logic w_hsv_ok;
    ckpm_hsv_pipe u_hsv (
        .i_clk         (i_clk),
        .i_adv         (w_adv[2:0]),
        .i_red         (w_r),
        .i_green       (w_g),
        .i_blue        (w_b),
        .i_flags       (r_flags),
        .i_target_hsv  (r_thsv),
        .i_hsv_spreads (r_spread),
        .o_hsv_ok      (w_hsv_ok)
    );

    // stage 4: output register
    logic [7:0] r_mask;
    logic       w_ok;
    assign w_ok = !r_excl[3] && (r_flags.hsv_mode ? w_hsv_ok : r_rgb_ok);
    always_ff @(posedge i_clk) begin
        if (w_adv[3]) r_mask <= w_ok ? ckpm_pkg::MaskOn : ckpm_pkg::MaskOff;
    end
    assign m_axis_tdata = r_mask;

`ifndef SYNTHESIS
    a_mask_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata == ckpm_pkg::MaskOn
                           || m_axis_tdata == ckpm_pkg::MaskOff))
        else $error("mask value not 0 or 255");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld == 4'hF && !m_axis_tready) |-> !s_axis_tready)
        else $error("accepted beat into a full stalled pipeline");
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !r_vld[3]) |=> r_vld[3])
        else $error("beat lost between last stages");
`endif
endmodule

### sim/tb_top.sv
// Testbench for the color key pixel mask core: predicted mask bytes vs. the stream output.
`timescale 1ns / 1ps
module tb_top;
    localparam int unsigned IdxBits = 22;
    localparam int unsigned InW = ((IdxBits + 32 + 7) / 8) * 8;
    localparam int unsigned IdxMax = (1 << IdxBits) - 1;

    typedef struct packed {
        logic [IdxBits-1:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha_value;
    } t_pixel;

    class mask_scoreboard;
        logic [5:0]  flags;
        logic [9:0]  limit;
        logic [23:0] trgb, thsv, spreads;
        logic [22:0] frame_pixels;
        logic [7:0]  pending_masks[$];
        int          mismatches;

        function void write_reg(logic [2:0] idx, logic [23:0] val);
            case (idx)
                ckpm_pkg::REG_CONTROL_FLAGS:  flags = val[5:0];
                ckpm_pkg::REG_DISTANCE_LIMIT: limit = val[9:0];
                ckpm_pkg::REG_TARGET_RGB:     trgb = val;
                ckpm_pkg::REG_TARGET_HSV:     thsv = val;
                ckpm_pkg::REG_HSV_SPREADS:    spreads = val;
                ckpm_pkg::REG_FRAME_PIXELS:   frame_pixels = val[22:0];
                default: ;
            endcase
        endfunction

        function int unsigned adiff(int unsigned a, int unsigned b);
            return a > b ? a - b : b - a;
        endfunction

        function int unsigned hue_of(int unsigned base, int unsigned p, int unsigned q,
                                     int unsigned den);
            int unsigned mag;
            mag = (43 * adiff(p, q)) / den;
            return ((p >= q) ? base + mag : base + 256 - mag) & 255;
        endfunction

        function bit hsv_ok(int unsigned r, int unsigned g, int unsigned b);
            int unsigned mx, mn, h, s, v, d;
            bit ok;
            mx = r; mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            v = mx; h = 0; s = 0; ok = 1;
            if (mx != 0) begin
                s = (255 * (mx - mn)) / mx;
                if (s != 0) begin
                    if (mx == r) h = hue_of(0, g, b, mx - mn);
                    else if (mx == g) h = hue_of(85, b, r, mx - mn);
                    else h = hue_of(171, r, g, mx - mn);
                end
            end
            if (flags[3]) begin
                d = adiff(h, thsv[23:16]);
                if (d > 128) d = 255 - d;
                if (d > spreads[23:16]) ok = 0;
            end
            if (flags[4] && adiff(s, thsv[15:8]) > spreads[15:8]) ok = 0;
            if (flags[5] && adiff(v, thsv[7:0]) > spreads[7:0]) ok = 0;
            return ok;
        endfunction

        function bit rgb_ok(int unsigned r, int unsigned g, int unsigned b);
            longint unsigned rmean, dr, dg, db, sum;
            rmean = (trgb[23:16] + r) / 2;
            dr = adiff(trgb[23:16], r);
            dg = adiff(trgb[15:8], g);
            db = adiff(trgb[7:0], b);
            sum = (((512 + rmean) * dr * dr) >> 8) + 4 * dg * dg
                + (((767 - rmean) * db * db) >> 8);
            return sum <= longint'(limit) * limit;
        endfunction

        function void note_pixel(t_pixel p);
            bit ok;
            if (flags[2] && p.pixel_index < (frame_pixels >> 1)) ok = 0;
            else if (flags[1] && p.alpha_value == 0) ok = 0;
            else if (flags[0]) ok = hsv_ok(p.red, p.green, p.blue);
            else ok = rgb_ok(p.red, p.green, p.blue);
            pending_masks.push_back(ok ? ckpm_pkg::MaskOn : ckpm_pkg::MaskOff);
        endfunction

        function void check_mask(logic [7:0] got);
            logic [7:0] want;
            if (pending_masks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected mask beat %0d", got);
                return;
            end
            want = pending_masks.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mask mismatch: expected %0d got %0d", want, got);
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic s_axis_tvalid = 0, s_axis_tready;
    logic [InW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid, m_axis_tready = 0;
    logic [7:0] m_axis_tdata;
    logic i_cfg_we = 0;
    logic [ckpm_pkg::CfgIdxBits-1:0] i_cfg_idx = '0;
    logic [ckpm_pkg::CfgDataBits-1:0] i_cfg_data = '0;

    mask_scoreboard sb = new();
    bit quiet_phase = 0;

    always #6 i_clk = ~i_clk;

    color_key_pixel_mask_core #(.PIXEL_INDEX_BITS(IdxBits)) uut (.*);

    task automatic cfg_write(logic [2:0] idx, logic [23:0] val);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, val);
    endtask

    task automatic send_pixel(t_pixel p);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= InW'({p.alpha_value, p.blue, p.green, p.red, p.pixel_index});
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_pixel(p);
    endtask

    task automatic drain;
        s_axis_tvalid <= 0;
        while (sb.pending_masks.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_pixel rand_pixel();
        t_pixel p;
        p.pixel_index = IdxBits'($urandom_range(0, IdxMax));
        if ($urandom_range(0, 1)) p.pixel_index = IdxBits'($urandom_range(0, 64));
        p.red = 8'($urandom); p.green = 8'($urandom); p.blue = 8'($urandom);
        p.alpha_value = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        return p;
    endfunction

    // pull some pixels near the target so matches happen often
    function automatic t_pixel near_pixel(logic [23:0] c);
        t_pixel p;
        p = rand_pixel();
        p.red = 8'(int'(c[23:16]) + $urandom_range(0, 16) - 8);
        p.green = 8'(int'(c[15:8]) + $urandom_range(0, 16) - 8);
        p.blue = 8'(int'(c[7:0]) + $urandom_range(0, 16) - 8);
        return p;
    endfunction

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) sb.check_mask(m_axis_tdata);
    end

    // output stall bursts
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 6);
                m_axis_tready <= 0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1;
        end
    end

    initial begin
        t_pixel p;
        logic [23:0] hsv_t;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset config, then extremes
        p = '{pixel_index: 0, red: 0, green: 0, blue: 0, alpha_value: 0};
        send_pixel(p);
        p = '{pixel_index: IdxMax, red: 255, green: 255, blue: 255, alpha_value: 255};
        send_pixel(p);
        drain();
        cfg_write(ckpm_pkg::REG_CONTROL_FLAGS, 24'h3f);
        cfg_write(ckpm_pkg::REG_DISTANCE_LIMIT, 24'h3ff);
        cfg_write(ckpm_pkg::REG_TARGET_RGB, 24'hffffff);
        cfg_write(ckpm_pkg::REG_TARGET_HSV, 24'hffffff);
        cfg_write(ckpm_pkg::REG_HSV_SPREADS, 24'hffffff);
        cfg_write(ckpm_pkg::REG_FRAME_PIXELS, 24'h400000);
        p = '{pixel_index: 100, red: 9, green: 9, blue: 9, alpha_value: 1};
        send_pixel(p); // before bottom-half start
        p = '{pixel_index: 24'h200000, red: 255, green: 0, blue: 0, alpha_value: 0};
        send_pixel(p); // alpha zero
        p = '{pixel_index: IdxMax, red: 255, green: 0, blue: 1, alpha_value: 7};
        send_pixel(p); // red max, hue wraps
        p = '{pixel_index: IdxMax, red: 1, green: 200, blue: 0, alpha_value: 7};
        send_pixel(p);
        p = '{pixel_index: IdxMax, red: 2, green: 0, blue: 250, alpha_value: 7};
        send_pixel(p);
        drain();
        cfg_write(ckpm_pkg::REG_CONTROL_FLAGS, 24'h39);
        cfg_write(ckpm_pkg::REG_TARGET_HSV, 24'h05c080);
        cfg_write(ckpm_pkg::REG_HSV_SPREADS, 24'h0a2020);
        cfg_write(ckpm_pkg::REG_FRAME_PIXELS, 24'h0);
        p = '{pixel_index: 0, red: 250, green: 60, blue: 70, alpha_value: 0};
        send_pixel(p);
        p = '{pixel_index: 0, red: 128, green: 128, blue: 128, alpha_value: 0};
        send_pixel(p);
        drain();
        cfg_write(ckpm_pkg::REG_CONTROL_FLAGS, 24'h01); // hsv, no checks
        send_pixel(rand_pixel());
        drain();
        cfg_write(ckpm_pkg::REG_CONTROL_FLAGS, 24'h00);
        cfg_write(ckpm_pkg::REG_DISTANCE_LIMIT, 24'h0);
        cfg_write(ckpm_pkg::REG_TARGET_RGB, 24'h000000);
        p = '{pixel_index: 3, red: 0, green: 0, blue: 0, alpha_value: 0};
        send_pixel(p);
        p = '{pixel_index: 3, red: 255, green: 255, blue: 255, alpha_value: 0};
        send_pixel(p);
        drain();

        // random phases with fresh settings
        for (int ph = 0; ph < 16; ph++) begin
            cfg_write(ckpm_pkg::REG_CONTROL_FLAGS, 24'($urandom_range(0, 63)));
            cfg_write(ckpm_pkg::REG_DISTANCE_LIMIT,
                      (ph % 4 == 0) ? 24'h3ff : 24'($urandom_range(0, 200)));
            cfg_write(ckpm_pkg::REG_TARGET_RGB, 24'($urandom));
            hsv_t = 24'($urandom);
            cfg_write(ckpm_pkg::REG_TARGET_HSV, hsv_t);
            cfg_write(ckpm_pkg::REG_HSV_SPREADS, 24'($urandom) & 24'h3f3f3f);
            cfg_write(ckpm_pkg::REG_FRAME_PIXELS,
                      (ph % 5 == 0) ? 24'h400000 : 24'($urandom_range(0, 128)));
            if (ph == 13) quiet_phase = 1;
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(0, 1)) send_pixel(near_pixel(sb.trgb));
                else send_pixel(rand_pixel());
            end
            drain();
        end
        if (sb.mismatches == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_top: FAIL");
        $finish;
    end
endmodule

### color_key_pixel_mask_core.f
rtl/ckpm_pkg.sv
rtl/ckpm_hsv_pipe.sv
rtl/color_key_pixel_mask_core.sv
sim/tb_top.sv
